// ----- rtl/mbmac_pkg.sv -----
// Shared types and constants for the minute bar moving-average crossover block.
`default_nettype none
package mbmac_pkg;
    localparam int MAX_WINDOW = 64;
    localparam int PRICE_W = 32;
    localparam int WIN_W   = 7;
    localparam int TIME_W  = 17;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } signal_t;

    localparam logic [0:0] REG_FAST = 1'b0;
    localparam logic [0:0] REG_SLOW = 1'b1;

    // divider request from sequencer
    typedef struct packed {
        logic        start;
        logic [37:0] dividend;
        logic [6:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/mbmac_divider.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module mbmac_divider (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mbmac_pkg::div_req_t req,
    output mbmac_pkg::div_rsp_t      rsp
);
    logic [37:0] quo_reg, quo_next;
    logic [6:0]  rem_reg, rem_next;
    logic [6:0]  dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [7:0]  trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[37]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd37;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = 7'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[36:0], 1'b1};
            end else begin
                rem_next = trial[6:0];
                quo_next = {quo_reg[36:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[31:0];
endmodule
`default_nettype wire

// ----- rtl/minute_bar_ma_crossover_top.sv -----
// Top level: tick to OHLC bar gathering, close history and SMA crossover sequencer.
//
//   channel   dir  handshake              payload
//   s_axis    in   s_tvalid/s_tready      tdata: tick fields, tlast: last_tick
//   m_axis    out  m_tvalid/m_tready      tdata: bar and averages, tuser: signal, tlast: see below
//   apb       in   psel/penable/pwrite    fast_window @0, slow_window @4
//
// A tick with no bar close passes through check, update and last-flag test.
// Each bar close writes the history, then walks it to rebuild both window sums
// (one read per cycle), then runs up to two 38-step divisions on the shared
// divider, then waits for the result to be taken. s_tready is low throughout.
// m_tlast is low only on the first of two results emitted for a last tick.
// Reset is synchronous; the close history is not cleared (sums that include unwritten
// entries are never divided, since averages need bar_count >= window).
`default_nettype none
module minute_bar_ma_crossover_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [4:0] tick_hour, [10:5] tick_minute, [16:11] tick_second, [48:17] price, pad
    input  wire logic [55:0]  s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [4:0] bar_hour, [10:5] bar_minute, [16:11] bar_second, [48:17] open_price,
    // [80:49] high_price, [112:81] low_price, [144:113] close_price,
    // [176:145] fast_average, [208:177] slow_average, pad
    output logic [215:0]      m_tdata,
    // [1:0] signal
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int MAX_WINDOW = mbmac_pkg::MAX_WINDOW;
    localparam int PW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = 32 + PW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_WRITE, ST_SUM, ST_DIVF, ST_WAITF, ST_DIVS, ST_WAITS,
        ST_EMIT, ST_UPDATE, ST_LAST
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]  fast_cfg_reg, slow_cfg_reg;

    // stored tick
    logic [16:0] tick_time_reg;
    logic [31:0] price_reg;
    logic        last_reg;
    logic        second_close_reg;  // currently handling last-tick close

    logic [31:0] hist_mem [MAX_WINDOW];
    logic [31:0] hist_rd_reg;
    logic [PW-1:0] hptr_reg;
    logic [CW-1:0] bcount_reg;
    logic [SW-1:0] fsum_reg, ssum_reg;
    logic [32:0]   prev_diff_reg;
    logic [31:0] open_reg, high_reg, low_reg, close_reg;
    logic [16:0] bar_time_reg;
    logic        open_flag_reg, started_reg;

    logic [CW-1:0] idx_reg;      // walk step
    logic          rd_ok_reg;
    logic [31:0] fa_reg, sa_reg;
    logic [1:0]  sig_reg;

    // clamped windows
    logic [CW-1:0] slow_n, fast_n, fast_c;
    always_comb begin
        if (slow_cfg_reg == '0) slow_n = CW'(1);
        else if (32'(slow_cfg_reg) > 32'(MAX_WINDOW)) slow_n = CW'(MAX_WINDOW);
        else slow_n = CW'(slow_cfg_reg);
        if (fast_cfg_reg == '0) fast_c = CW'(1);
        else if (32'(fast_cfg_reg) > 32'(MAX_WINDOW)) fast_c = CW'(MAX_WINDOW);
        else fast_c = CW'(fast_cfg_reg);
        fast_n = (fast_c > slow_n) ? slow_n : fast_c;
    end

    mbmac_pkg::div_req_t dreq;
    mbmac_pkg::div_rsp_t drsp;
    mbmac_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // a division is only started when its average is defined
    always_comb begin
        dreq.start    = ((state_reg == ST_DIVF) && (bcount_reg >= fast_n)) ||
                        ((state_reg == ST_DIVS) && (bcount_reg >= slow_n));
        dreq.dividend = (state_reg == ST_DIVF) ? 38'(fsum_reg) : 38'(ssum_reg);
        dreq.divisor  = (state_reg == ST_DIVF) ? 7'(fast_n) : 7'(slow_n);
    end

    logic [PW-1:0] rd_addr;
    assign rd_addr = PW'(hptr_reg - PW'(1) - PW'(idx_reg));

    // signal decision
    logic [32:0] cur_diff;
    logic        sig_ok;
    logic [1:0]  sig_val;
    always_comb begin
        cur_diff = {1'b0, fa_reg} - {1'b0, sa_reg};
        sig_ok   = (fa_reg != '0) && (sa_reg != '0) && (bcount_reg >= slow_n);
        sig_val  = mbmac_pkg::SIG_NONE;
        if (sig_ok && prev_diff_reg != '0) begin
            if (!prev_diff_reg[32] && cur_diff[32]) sig_val = mbmac_pkg::SIG_SELL;
            else if (prev_diff_reg[32] && !cur_diff[32] && cur_diff != '0)
                sig_val = mbmac_pkg::SIG_BUY;
        end
    end

    logic s_fire, m_fire;
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) hist_mem[hptr_reg] <= close_reg;
        hist_rd_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fast_cfg_reg  <= 7'd5;
            slow_cfg_reg  <= 7'd20;
            hptr_reg      <= '0;
            bcount_reg    <= '0;
            fsum_reg      <= '0;
            ssum_reg      <= '0;
            prev_diff_reg <= '0;
            open_reg      <= '0;
            high_reg      <= '0;
            low_reg       <= '1;
            close_reg     <= '0;
            bar_time_reg  <= '0;
            open_flag_reg <= 1'b0;
            started_reg   <= 1'b0;
            m_tvalid      <= 1'b0;
            m_tlast       <= 1'b0;
            second_close_reg <= 1'b0;
            idx_reg       <= '0;
            rd_ok_reg     <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == mbmac_pkg::REG_FAST) fast_cfg_reg <= pwdata[6:0];
                else slow_cfg_reg <= pwdata[6:0];
            end
            unique case (state_reg)
                ST_IDLE: if (s_fire) begin
                    tick_time_reg <= {s_tdata[4:0], s_tdata[10:5], s_tdata[16:11]};
                    price_reg     <= s_tdata[48:17];
                    last_reg      <= s_tlast;
                    second_close_reg <= 1'b0;
                    if (!started_reg) begin
                        started_reg  <= 1'b1;
                        bar_time_reg <= {s_tdata[4:0], s_tdata[10:5], s_tdata[16:11]};
                    end
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (bar_time_reg[11:6] != tick_time_reg[11:6]) state_reg <= ST_WRITE;
                    else state_reg <= ST_UPDATE;
                end
                ST_WRITE: begin
                    hptr_reg <= PW'(hptr_reg + PW'(1));
                    if (32'(bcount_reg) < MAX_WINDOW) bcount_reg <= CW'(bcount_reg + CW'(1));
                    fsum_reg  <= '0;
                    ssum_reg  <= '0;
                    idx_reg   <= '0;
                    rd_ok_reg <= 1'b0;
                    fa_reg    <= '0;
                    sa_reg    <= '0;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    // one history read per cycle, accumulated in the following cycle
                    if (rd_ok_reg) begin
                        if (CW'(idx_reg - CW'(1)) < fast_n)
                            fsum_reg <= SW'(fsum_reg + SW'(hist_rd_reg));
                        ssum_reg <= SW'(ssum_reg + SW'(hist_rd_reg));
                    end
                    if (idx_reg == slow_n) state_reg <= ST_DIVF;
                    else begin
                        idx_reg   <= CW'(idx_reg + CW'(1));
                        rd_ok_reg <= 1'b1;
                    end
                end
                ST_DIVF: state_reg <= (bcount_reg >= fast_n) ? ST_WAITF : ST_DIVS;
                ST_WAITF: if (drsp.done) begin
                    fa_reg    <= drsp.quotient;
                    state_reg <= ST_DIVS;
                end
                ST_DIVS: state_reg <= (bcount_reg >= slow_n) ? ST_WAITS : ST_EMIT;
                ST_WAITS: if (drsp.done) begin
                    sa_reg    <= drsp.quotient;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_tvalid) begin
                        m_tdata <= {7'd0, sa_reg, fa_reg, close_reg, low_reg, high_reg,
                                    open_reg, bar_time_reg[5:0], bar_time_reg[11:6],
                                    bar_time_reg[16:12]};
                        m_tuser <= sig_val;
                        m_tlast <= second_close_reg || !last_reg;
                        m_tvalid <= 1'b1;
                        if (sig_ok) prev_diff_reg <= cur_diff;
                        open_flag_reg <= 1'b0;
                        high_reg      <= '0;
                        low_reg       <= '1;
                        bar_time_reg  <= tick_time_reg;
                    end else if (m_fire) begin
                        m_tvalid  <= 1'b0;
                        state_reg <= second_close_reg ? ST_IDLE : ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (!open_flag_reg) begin
                        open_flag_reg <= 1'b1;
                        open_reg      <= price_reg;
                    end
                    if (price_reg < low_reg) low_reg <= price_reg;
                    if (price_reg > high_reg) high_reg <= price_reg;
                    close_reg <= price_reg;
                    state_reg <= ST_LAST;
                end
                ST_LAST: begin
                    if (last_reg) begin
                        second_close_reg <= 1'b1;
                        state_reg <= ST_WRITE;
                    end else state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mbmac_pkg::REG_FAST) ? {25'd0, fast_cfg_reg}
                                                      : {25'd0, slow_cfg_reg};

    // result payload holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    // no new item while a result is pending
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken with result pending");
    // divider only finishes while waited for
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.done |-> (state_reg == ST_WAITF || state_reg == ST_WAITS))
        else $error("stray divider completion");
endmodule
`default_nettype wire
